// ===== rtl/dali_level_frame_transmitter_macros.svh =====
// Assertion macros shared by the DALI level frame transmitter RTL.
`ifndef DALI_LEVEL_FRAME_TRANSMITTER_MACROS_SVH
`define DALI_LEVEL_FRAME_TRANSMITTER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DLFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DLFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dlft_pkg.sv =====
// Package with the types, constants and helper functions of the DALI level frame transmitter.
package dlft_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int HB_INDEX_WIDTH = 6;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HALF_BIT_TICKS = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_TICKS = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SETTLE_TICKS = 2'd2;

  localparam logic [CFG_DATA_WIDTH-1:0] HALF_BIT_TICKS_RESET = 16'd416;
  localparam logic [CFG_DATA_WIDTH-1:0] GAP_TICKS_RESET = 16'd15000;
  localparam logic [CFG_DATA_WIDTH-1:0] SETTLE_TICKS_RESET = 16'd10000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET_LEVEL = 1'b1;

  localparam logic [7:0] LEVEL_MAX = 8'd254;
  localparam logic [HB_INDEX_WIDTH-1:0] HALF_BITS_PER_FRAME = 6'd34;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FRAME1 = 5'b00010,
    PH_GAP    = 5'b00100,
    PH_FRAME2 = 5'b01000,
    PH_SETTLE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic               operation;
    logic [5:0]         short_address;
    logic signed [15:0] requested_level;
  } in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } out_t;

  // Frame layout: address byte 0AAAAAA0 followed by the clamped level byte.
  function automatic logic [15:0] build_frame(input logic [5:0] addr,
                                              input logic signed [15:0] raw);
    logic [7:0] level;
    begin
      if (raw[15]) begin
        level = 8'd0;
      end else if (raw > $signed({8'd0, LEVEL_MAX})) begin
        level = LEVEL_MAX;
      end else begin
        level = raw[7:0];
      end
      return {1'b0, addr, 1'b0, level};
    end
  endfunction

  // Line level during half-bit h: start bit first, then the 16 frame bits MSB first.
  function automatic logic half_bit_value(input logic [15:0] frame,
                                          input logic [HB_INDEX_WIDTH-1:0] h);
    logic [4:0] bitno;
    logic [4:0] pos;
    logic       v;
    begin
      bitno = h[HB_INDEX_WIDTH-1:1];
      pos = 5'd16 - bitno;
      if (bitno == 5'd0) begin
        v = 1'b1;
      end else if (bitno <= 5'd16) begin
        v = frame[pos[3:0]];
      end else begin
        v = 1'b0;
      end
      return h[0] ? ~v : v;
    end
  endfunction

endpackage

// ===== rtl/dali_level_frame_transmitter.sv =====
// Top level of the DALI set-level forward frame transmitter with its timing and output register.
// The block takes one transaction per clock: either a one-microsecond tick or a set-level
// command. Each input transaction is handled combinationally and its result (line level,
// busy flag, accepted flag) appears in the result register on the following clock; input is
// stalled only while that register holds a result that has not been taken. A command sends the
// 17-bit forward frame twice with the configured half-bit, gap and settle times, all counted in
// ticks; a command that arrives while a transmission runs is dropped and reported as not
// accepted. Timing registers may be rewritten at any time and take effect on the next tick.
`include "dali_level_frame_transmitter_macros.svh"

module dali_level_frame_transmitter #(
  parameter int COUNT_WIDTH = dlft_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  dlft_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output dlft_pkg::out_t                        out_data,
  input  logic                                  cfg_write,
  input  logic [dlft_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [dlft_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  localparam int LW = (COUNT_WIDTH > dlft_pkg::CFG_DATA_WIDTH) ?
                      COUNT_WIDTH : dlft_pkg::CFG_DATA_WIDTH;
  localparam logic [LW-1:0] CNT_MAX_EXT = LW'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
  localparam logic [dlft_pkg::HB_INDEX_WIDTH-1:0] HB_ZERO = '0;

  logic [dlft_pkg::CFG_DATA_WIDTH-1:0] half_bit_ticks;
  logic [dlft_pkg::CFG_DATA_WIDTH-1:0] gap_ticks;
  logic [dlft_pkg::CFG_DATA_WIDTH-1:0] settle_ticks;

  dlft_pkg::phase_t                     phase, phase_next;
  logic [15:0]                          frame_bits, frame_bits_next;
  logic [dlft_pkg::HB_INDEX_WIDTH-1:0]  half_bit_index, half_bit_index_next;
  logic [COUNT_WIDTH-1:0]               tick_count, tick_count_next;
  logic                                 pin_level, pin_level_next;
  logic                                 accepted_next;

  logic                                 in_fire;
  logic [COUNT_WIDTH-1:0]               tick_inc;
  logic [COUNT_WIDTH-1:0]               half_lim;
  logic [COUNT_WIDTH-1:0]               gap_lim;
  logic [COUNT_WIDTH-1:0]               settle_lim;
  logic [dlft_pkg::HB_INDEX_WIDTH-1:0]  index_inc;
  logic [15:0]                          new_frame;

  function automatic logic [COUNT_WIDTH-1:0] limit_of(
      input logic [dlft_pkg::CFG_DATA_WIDTH-1:0] r);
    logic [LW-1:0] e;
    begin
      e = LW'(r);
      if (e > CNT_MAX_EXT) begin
        e = CNT_MAX_EXT;
      end
      return COUNT_WIDTH'(e);
    end
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign in_fire = in_valid && in_ready;

  assign tick_inc = tick_count + CNT_ONE;
  assign index_inc = half_bit_index + dlft_pkg::HB_INDEX_WIDTH'(1);
  assign gap_lim = limit_of(gap_ticks);
  assign settle_lim = limit_of(settle_ticks);
  assign half_lim = (limit_of(half_bit_ticks) == CNT_ZERO) ? CNT_ONE : limit_of(half_bit_ticks);
  assign new_frame = dlft_pkg::build_frame(in_data.short_address, in_data.requested_level);

  always_comb begin
    phase_next = phase;
    frame_bits_next = frame_bits;
    half_bit_index_next = half_bit_index;
    tick_count_next = tick_count;
    pin_level_next = pin_level;
    accepted_next = 1'b0;
    if (in_data.operation == dlft_pkg::OP_SET_LEVEL) begin
      if (phase == dlft_pkg::PH_IDLE) begin
        frame_bits_next = new_frame;
        phase_next = dlft_pkg::PH_FRAME1;
        half_bit_index_next = HB_ZERO;
        tick_count_next = CNT_ZERO;
        pin_level_next = dlft_pkg::half_bit_value(new_frame, HB_ZERO);
        accepted_next = 1'b1;
      end
    end else begin
      case (phase)
        dlft_pkg::PH_FRAME1, dlft_pkg::PH_FRAME2: begin
          tick_count_next = tick_inc;
          if (tick_inc >= half_lim) begin
            tick_count_next = CNT_ZERO;
            if (index_inc >= dlft_pkg::HALF_BITS_PER_FRAME) begin
              half_bit_index_next = HB_ZERO;
              pin_level_next = 1'b0;
              if (phase == dlft_pkg::PH_FRAME1) begin
                if (gap_lim == CNT_ZERO) begin
                  phase_next = dlft_pkg::PH_FRAME2;
                  pin_level_next = dlft_pkg::half_bit_value(frame_bits, HB_ZERO);
                end else begin
                  phase_next = dlft_pkg::PH_GAP;
                end
              end else if (settle_lim == CNT_ZERO) begin
                phase_next = dlft_pkg::PH_IDLE;
              end else begin
                phase_next = dlft_pkg::PH_SETTLE;
              end
            end else begin
              half_bit_index_next = index_inc;
              pin_level_next = dlft_pkg::half_bit_value(frame_bits, index_inc);
            end
          end
        end
        dlft_pkg::PH_GAP: begin
          tick_count_next = tick_inc;
          if (tick_inc >= gap_lim) begin
            phase_next = dlft_pkg::PH_FRAME2;
            half_bit_index_next = HB_ZERO;
            tick_count_next = CNT_ZERO;
            pin_level_next = dlft_pkg::half_bit_value(frame_bits, HB_ZERO);
          end
        end
        dlft_pkg::PH_SETTLE: begin
          tick_count_next = tick_inc;
          if (tick_inc >= settle_lim) begin
            tick_count_next = CNT_ZERO;
            phase_next = dlft_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = dlft_pkg::PH_IDLE;
          pin_level_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks <= dlft_pkg::HALF_BIT_TICKS_RESET;
      gap_ticks <= dlft_pkg::GAP_TICKS_RESET;
      settle_ticks <= dlft_pkg::SETTLE_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dlft_pkg::CFG_HALF_BIT_TICKS: half_bit_ticks <= cfg_data;
        dlft_pkg::CFG_GAP_TICKS:      gap_ticks <= cfg_data;
        dlft_pkg::CFG_SETTLE_TICKS:   settle_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dlft_pkg::PH_IDLE;
      frame_bits <= '0;
      half_bit_index <= HB_ZERO;
      tick_count <= CNT_ZERO;
      pin_level <= 1'b0;
    end else if (in_fire) begin
      phase <= phase_next;
      frame_bits <= frame_bits_next;
      half_bit_index <= half_bit_index_next;
      tick_count <= tick_count_next;
      pin_level <= pin_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.line_level <= pin_level_next;
      out_data.busy_res <= (phase_next != dlft_pkg::PH_IDLE);
      out_data.accepted <= accepted_next;
    end
  end

  `DLFT_ASSERT_NOW(a_accept_busy, clk, rst, out_valid && out_data.accepted, out_data.busy_res, "accepted command without busy")
  `DLFT_ASSERT_NOW(a_line_idle_low, clk, rst, out_valid && out_data.line_level, out_data.busy_res, "line high while idle")
  `DLFT_ASSERT_NOW(a_idle_count_clear, clk, rst, phase == dlft_pkg::PH_IDLE, tick_count == CNT_ZERO && pin_level == 1'b0, "idle with running count or high line")
  `DLFT_ASSERT_NOW(a_index_range, clk, rst, 1'b1, half_bit_index < dlft_pkg::HALF_BITS_PER_FRAME, "half-bit index out of frame")
  `DLFT_ASSERT_NEXT(a_busy_drop, clk, rst, in_fire && in_data.operation == dlft_pkg::OP_SET_LEVEL && phase != dlft_pkg::PH_IDLE, !out_data.accepted && $stable(frame_bits), "command taken while busy")

endmodule
